// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while in reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never hold on a rising clock edge
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/core/qct_pkg.sv -----
package qct_pkg;

	// limits of one command
	localparam int MAX_LEN  = 1024;
	localparam int MAX_ARGS = 128;

	// length saturates at MAX_LEN+1, argument total stops at MAX_ARGS
	localparam int LEN_W  = $clog2(MAX_LEN + 2);
	localparam int ARGS_W = $clog2(MAX_ARGS + 1);
	localparam int CNT_W  = (ARGS_W > 8) ? ARGS_W : 8;

	// queue between classifier and output stage, power of two
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_ARG_END = 2'd1,
		KIND_CMD_END = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_NO_QUOTE = 2'd2,
		ST_TOO_MANY = 2'd3
	} status_t;

	// one output beat
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  arg_byte;
		logic [6:0]  arg_index;
		logic [7:0]  arg_count;
		status_t     status;
		logic        last_of_run;
	} result_t;

	// everything one input byte produces: one or two beats
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ----- rtl/core/qct_fifo.sv -----
`include "assert_macros.svh"

module qct_fifo
	import qct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  entry_t     push_data,
	input  logic       pop,
	output entry_t     pop_data,
	output fifo_stat_t stat
);

	entry_t           mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign stat.full  = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	`ASSERT_NEVER(a_fifo_overrun, push && stat.full, "push into full queue")
	`ASSERT_NEVER(a_fifo_underrun, pop && stat.empty, "pop from empty queue")
	`ASSERT_CLK(a_fifo_ptrs, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q), "empty queue, pointers differ")

endmodule

// ----- rtl/core/qct_front.sv -----
`include "assert_macros.svh"

module qct_front
	import qct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	input  fifo_stat_t fstat,
	output logic       push,
	output entry_t     push_data
);

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_PLAIN  = 2'd1,
		MODE_QUOTED = 2'd2
	} mode_t;

	logic              skip_q, skip_d;
	logic              par_q, par_d;
	mode_t             mode_q, mode_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [ARGS_W-1:0] tot_q, tot_d;
	status_t           err_q, err_d;

	logic       accept;
	logic       is_quote, is_space, is_delim, is_nul;
	logic       do_end, end_skip, do_close;
	logic       has_byte, has_cmd;
	result_t    byte_res, cmd_res;
	logic [CNT_W-1:0] tot_ext;
	logic [6:0] cur_idx;

	assign in_stall = fstat.full;
	assign accept   = in_valid && !fstat.full;

	assign is_quote = (text_byte == CH_QUOTE);
	assign is_space = (text_byte == CH_SPACE) || (text_byte == CH_TAB);
	assign is_delim = (text_byte == CH_SEMI) || (text_byte == CH_CR) || (text_byte == CH_LF);
	assign is_nul   = (text_byte == CH_NUL);

	// argument index saturates at 127
	assign tot_ext = CNT_W'(tot_q);
	assign cur_idx = (tot_ext > CNT_W'(127)) ? 7'h7F : tot_ext[6:0];

	always_comb begin
		skip_d   = skip_q;
		par_d    = par_q;
		mode_d   = mode_q;
		len_d    = len_q;
		tot_d    = tot_q;
		err_d    = err_q;
		do_end   = 1'b0;
		end_skip = 1'b0;
		do_close = 1'b0;
		has_byte = 1'b0;
		has_cmd  = 1'b0;
		byte_res = '0;
		cmd_res  = '0;

		if (skip_q && (is_delim || is_space)) begin
			if (end_of_text) skip_d = 1'b0;
		end else begin
			skip_d = 1'b0;
			if (is_nul) begin
				if (len_q != '0) begin
					do_end = 1'b1;
				end else begin
					par_d  = 1'b0;
					mode_d = MODE_IDLE;
					len_d  = '0;
					tot_d  = '0;
					err_d  = ST_OK;
				end
			end else begin
				par_d = par_q ^ is_quote;
				if (is_delim && !par_d) begin
					do_end   = 1'b1;
					end_skip = !end_of_text;
				end else begin
					if (len_q <= LEN_W'(MAX_LEN)) len_d = len_q + 1'b1;
					if (len_d > LEN_W'(MAX_LEN)) err_d = ST_TOO_LONG;
					byte_res.arg_index = cur_idx;
					byte_res.arg_byte  = text_byte;
					byte_res.kind      = KIND_BYTE;
					case (mode_q)
						MODE_IDLE: begin
							if (is_quote) begin
								mode_d = MODE_QUOTED;
							end else if (!is_space) begin
								mode_d   = MODE_PLAIN;
								has_byte = 1'b1;
							end
						end
						MODE_PLAIN: begin
							has_byte = 1'b1;
							if (is_space) begin
								do_close = 1'b1;
								mode_d   = MODE_IDLE;
							end
						end
						default: begin
							has_byte = 1'b1;
							if (is_quote) begin
								do_close = 1'b1;
								mode_d   = MODE_IDLE;
							end
						end
					endcase
					if (do_close) begin
						byte_res.kind     = KIND_ARG_END;
						byte_res.arg_byte = '0;
						if (tot_q >= ARGS_W'(MAX_ARGS)) begin
							if (err_d == ST_OK) err_d = ST_TOO_MANY;
						end else begin
							tot_d = tot_q + 1'b1;
						end
					end
					do_end = end_of_text;
				end
			end
		end

		if (do_end) begin
			// an open plain argument is closed by the command end
			if (mode_d == MODE_PLAIN) begin
				if (tot_d >= ARGS_W'(MAX_ARGS)) begin
					if (err_d == ST_OK) err_d = ST_TOO_MANY;
				end else begin
					tot_d = tot_d + 1'b1;
				end
			end
			has_cmd           = 1'b1;
			cmd_res.kind      = KIND_CMD_END;
			cmd_res.arg_count = 8'(CNT_W'(tot_d));
			if (len_d > LEN_W'(MAX_LEN))  cmd_res.status = ST_TOO_LONG;
			else if (err_d != ST_OK)      cmd_res.status = err_d;
			else if (mode_d == MODE_QUOTED) cmd_res.status = ST_NO_QUOTE;
			else                          cmd_res.status = ST_OK;
			cmd_res.last_of_run = 1'b1;
			skip_d = end_skip;
			par_d  = 1'b0;
			mode_d = MODE_IDLE;
			len_d  = '0;
			tot_d  = '0;
			err_d  = ST_OK;
		end

		byte_res.last_of_run = !has_cmd;
	end

	assign push           = accept && (has_byte || has_cmd);
	assign push_data.two  = has_byte && has_cmd;
	assign push_data.r0   = has_byte ? byte_res : cmd_res;
	assign push_data.r1   = cmd_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
			par_q  <= 1'b0;
			mode_q <= MODE_IDLE;
			len_q  <= '0;
			tot_q  <= '0;
			err_q  <= ST_OK;
		end else if (accept) begin
			skip_q <= skip_d;
			par_q  <= par_d;
			mode_q <= mode_d;
			len_q  <= len_d;
			tot_q  <= tot_d;
			err_q  <= err_d;
		end
	end

	`ASSERT_CLK(a_skip_clean, skip_q |-> (mode_q == MODE_IDLE && len_q == '0 && tot_q == '0), "skip with open command")
	`ASSERT_CLK(a_len_err, (len_q > LEN_W'(MAX_LEN)) |-> (err_q == ST_TOO_LONG), "overlong command without error")
	`ASSERT_CLK(a_tot_cap, tot_q <= ARGS_W'(MAX_ARGS), "argument total above cap")

endmodule

// ----- rtl/core/qct_back.sv -----
`include "assert_macros.svh"

module qct_back
	import qct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  fifo_stat_t fstat,
	input  entry_t     pop_data,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] arg_byte,
	output logic [6:0] arg_index,
	output logic [7:0] arg_count,
	output logic [1:0] status,
	output logic       last_of_run
);

	logic    out_valid_q;
	result_t out_q;
	logic    pend_q;
	result_t pend_res_q;
	logic    out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = out_free && !pend_q && !fstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (!fstat.empty) begin
				out_valid_q <= 1'b1;
				pend_q      <= pop_data.two;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				out_q <= pend_res_q;
			end else if (!fstat.empty) begin
				out_q      <= pop_data.r0;
				pend_res_q <= pop_data.r1;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign arg_byte    = out_q.arg_byte;
	assign arg_index   = out_q.arg_index;
	assign arg_count   = out_q.arg_count;
	assign status      = out_q.status;
	assign last_of_run = out_q.last_of_run;

	`ASSERT_CLK(a_pend_shown, pend_q |-> (out_valid_q && !out_q.last_of_run), "second beat pending behind wrong beat")
	`ASSERT_CLK(a_cmd_last, (out_valid_q && out_q.kind == KIND_CMD_END) |-> out_q.last_of_run, "command end not last")

endmodule

// ----- rtl/core/quoted_command_tokenizer.sv -----
// channel | beat                                                  | handshake
// --------+-------------------------------------------------------+---------------------
// in      | text_byte, end_of_text                                | in_valid / in_stall
// out     | kind, arg_byte, arg_index, arg_count, status, last_of_run | out_valid / out_stall
//
// one text byte accepted per cycle while in_stall is low; a byte that yields two beats (end of text
// inside an argument) sends them out one after the other at the output port
// a result beat passes through the queue and then the output reg before it reaches the output
// in_stall rises only when the four-entry queue is full; out_stall holds the output reg
// reset is asynchronous, clears all control state; no clearing pass, no startup cycles
module quoted_command_tokenizer
	import qct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// input beats
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	// result beats
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] arg_byte,
	output logic [6:0] arg_index,
	output logic [7:0] arg_count,
	output logic [1:0] status,
	output logic       last_of_run
);

	// queue status, shared by both sides
	fifo_stat_t fstat;
	// front side writes one entry per byte that has results
	logic       push;
	entry_t     push_data;
	// back side takes one entry when its output reg frees up and no second beat is pending
	logic       pop;
	entry_t     pop_data;

	// front: classifies the byte, tracks quotes, tokens, length, argument total
	qct_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.fstat       (fstat),
		.push        (push),
		.push_data   (push_data)
	);

	// short queue so the two sides stall independently
	qct_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (fstat)
	);

	// back: splits each entry into one or two beats behind an output register
	qct_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fstat       (fstat),
		.pop_data    (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.arg_byte    (arg_byte),
		.arg_index   (arg_index),
		.arg_count   (arg_count),
		.status      (status),
		.last_of_run (last_of_run)
	);

endmodule
